// ===== hdl/mwrs_pkg.sv =====
// Shared types, constants and widths of the masked weighted rate map smoother.
`default_nettype none
package mwrs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int PXW        = 41;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] W_SIDE   = 17'd65536;
    localparam logic [16:0] W_CORNER = 17'd46341;
    localparam logic [23:0] RATE_MAX = 24'hFFFFFF;

    localparam int NW = 19;   // sum of neighbor weights
    localparam int SW = 35;   // weighted spike sum
    localparam int TW = 43;   // weighted time sum
    localparam int AW = 20;   // blend coefficients
    localparam int NUMW = 63; // shifted numerator
    localparam int DENW = 63;
    localparam int QW = 25;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_SMOOTHING  = 2'd2,
        REG_THRESHOLD  = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [XW-1:0] pixel_x;
        logic [YW-1:0] pixel_y;
        logic          skip;
        logic [15:0]   c_spikes;
        logic [23:0]   c_time;
        logic [NW-1:0] n_sum;
        logic [SW-1:0] s_sum;
        logic [TW-1:0] t_sum;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AB,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_back_state;

    function automatic logic [16:0] weight_of(input int idx);
        logic [16:0] w;
        case (idx)
            0, 2, 6, 8: w = W_CORNER;
            1, 3, 5, 7: w = W_SIDE;
            default:    w = 17'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mwrs_if.sv =====
// Stream and configuration channel interfaces of the rate map smoother.
`default_nettype none
interface mwrs_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] spike_count;
    logic [23:0] dwell_time;
    logic        occupied;
    modport source (output valid, spike_count, dwell_time, occupied, input ready);
    modport sink (input valid, spike_count, dwell_time, occupied, output ready);
endinterface

interface mwrs_res_if;
    logic                      valid;
    logic                      ready;
    logic [mwrs_pkg::XW-1:0]   pixel_x;
    logic [mwrs_pkg::YW-1:0]   pixel_y;
    logic [23:0]               rate;
    logic                      no_rate;
    modport source (output valid, pixel_x, pixel_y, rate, no_rate, input ready);
    modport sink (input valid, pixel_x, pixel_y, rate, no_rate, output ready);
endinterface

interface mwrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mwrs_front.sv =====
// Front end: line stores, 3x3 window, position counters and neighbor sums.
`default_nettype none
module mwrs_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [6:0]       i_width,
    input  wire logic [6:0]       i_height,
    mwrs_pix_if.sink              i_pix,
    input  wire logic             i_full,
    output logic                  o_push,
    output mwrs_pkg::t_job        o_job
);
    localparam int PXW = mwrs_pkg::PXW;
    localparam int XW  = mwrs_pkg::XW;
    localparam int YW  = mwrs_pkg::YW;

    logic [2*PXW-1:0] r_mem [mwrs_pkg::MAX_WIDTH];
    logic [2*PXW-1:0] r_rd;
    logic [PXW-1:0]   r_win [9];
    logic [PXW-1:0]   n_win [9];
    logic [XW-1:0]    r_x, n_x;
    logic [YW-1:0]    r_y, n_y;
    logic             r_calc;
    logic [XW-1:0]    r_ox;
    logic [YW-1:0]    r_oy;
    logic             accept;
    logic             last_col;
    logic [PXW-1:0]   pix;
    logic [PXW-1:0]   top;
    logic [PXW-1:0]   mid;
    logic [mwrs_pkg::NW-1:0] n_acc;
    logic [mwrs_pkg::SW-1:0] s_acc;
    logic [mwrs_pkg::TW-1:0] t_acc;

    assign i_pix.ready = !r_calc || !i_full;
    assign accept      = i_pix.valid && i_pix.ready;
    assign o_push      = r_calc && !i_full;

    assign pix = {i_pix.occupied, i_pix.dwell_time, i_pix.spike_count};
    assign top = r_rd[2*PXW-1:PXW];
    assign mid = r_rd[PXW-1:0];

    assign last_col = ({1'b0, r_x} + 7'd1) >= i_width;

    always_comb begin
        n_x = r_x + 1'b1;
        n_y = r_y;
        if (last_col) begin
            n_x = '0;
            n_y = (({1'b0, r_y} + 7'd1) >= i_height) ? '0 : r_y + 1'b1;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = pix;
    end

    // line store: write the current column, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_x] <= {mid, pix};
            r_rd       <= r_mem[n_x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_calc <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_x <= n_x;
                r_y <= n_y;
                r_win <= n_win;
                r_calc <= (r_x >= XW'(2)) && (r_y >= YW'(2));
            end else if (o_push) begin
                r_calc <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ox <= r_x - 1'b1;
            r_oy <= r_y - 1'b1;
        end
    end

    always_comb begin
        n_acc = '0;
        s_acc = '0;
        t_acc = '0;
        for (int i = 0; i < 9; i++) begin
            if (r_win[i][PXW-1]) begin
                n_acc = n_acc + mwrs_pkg::NW'(mwrs_pkg::weight_of(i));
                s_acc = s_acc + mwrs_pkg::SW'(r_win[i][15:0]) *
                                mwrs_pkg::SW'(mwrs_pkg::weight_of(i));
                t_acc = t_acc + mwrs_pkg::TW'(r_win[i][39:16]) *
                                mwrs_pkg::TW'(mwrs_pkg::weight_of(i));
            end
        end
    end

    always_comb begin
        o_job.pixel_x  = r_ox;
        o_job.pixel_y  = r_oy;
        o_job.c_spikes = r_win[4][15:0];
        o_job.c_time   = r_win[4][39:16];
        o_job.skip     = !r_win[4][PXW-1] || (r_win[4][39:16] == 24'd0);
        o_job.n_sum    = n_acc;
        o_job.s_sum    = s_acc;
        o_job.t_sum    = t_acc;
    end

endmodule
`default_nettype wire

// ===== hdl/mwrs_fifo.sv =====
// Four-entry job queue between the front end and the divider back end.
`default_nettype none
module mwrs_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mwrs_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output mwrs_pkg::t_job      o_job
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    mwrs_pkg::t_job r_q [DEPTH];
    logic [PW-1:0]  r_wr, r_rdp;
    logic [PW:0]    r_cnt;

    assign o_full  = r_cnt == (PW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_q[r_rdp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rdp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rdp <= r_rdp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mwrs_back.sv =====
// Back end: blend coefficients, products and a radix-2 divider per item.
`default_nettype none
module mwrs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [16:0]    i_smooth,
    input  wire logic [23:0]    i_thresh,
    input  wire logic           i_valid,
    input  wire mwrs_pkg::t_job i_job,
    output logic                o_pop,
    mwrs_res_if.source          o_res
);
    localparam int AW   = mwrs_pkg::AW;
    localparam int NUMW = mwrs_pkg::NUMW;
    localparam int DENW = mwrs_pkg::DENW;
    localparam int QW   = mwrs_pkg::QW;
    localparam int DW   = DENW + QW - 1;

    mwrs_pkg::t_back_state r_st, n_st;
    mwrs_pkg::t_job        r_job;
    logic [AW-1:0]   r_a, r_b;
    logic [34:0]     r_pa;
    logic [54:0]     r_pb;
    logic [42:0]     r_qa;
    logic [61:0]     r_qb;
    logic [NUMW-1:0] r_rem;
    logic [DW-1:0]   r_div;
    logic [QW-1:0]   r_q;
    logic [4:0]      r_cnt;
    logic            r_ovalid;
    logic            out_free;
    logic            load_out;
    logic            ge;
    logic [35:0]     prod_a, prod_b;
    logic [23:0]     sat;

    function automatic logic [16:0] ONE_MINUS_SF();
        return mwrs_pkg::ONE_Q16 - i_smooth;
    endfunction

    assign out_free = !r_ovalid || o_res.ready;
    assign ge = {{(DW-NUMW){1'b0}}, r_rem} >= r_div;
    assign prod_a = 36'(ONE_MINUS_SF()) * 36'(r_job.n_sum);
    assign prod_b = 36'(i_smooth) * 36'(r_job.n_sum);
    assign sat = r_q[QW-1] ? mwrs_pkg::RATE_MAX : r_q[23:0];

    always_comb begin
        n_st = r_st;
        case (r_st)
            mwrs_pkg::ST_IDLE: if (i_valid) n_st = i_job.skip ? mwrs_pkg::ST_DONE : mwrs_pkg::ST_AB;
            mwrs_pkg::ST_AB:   n_st = mwrs_pkg::ST_MUL;
            mwrs_pkg::ST_MUL:  n_st = mwrs_pkg::ST_SUM;
            mwrs_pkg::ST_SUM:  n_st = mwrs_pkg::ST_DIV;
            mwrs_pkg::ST_DIV:  if (r_cnt == '0) n_st = mwrs_pkg::ST_DONE;
            mwrs_pkg::ST_DONE: if (out_free) n_st = mwrs_pkg::ST_IDLE;
            default:           n_st = mwrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_st)
            mwrs_pkg::ST_IDLE: o_pop = i_valid;
            mwrs_pkg::ST_DONE: load_out = out_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= mwrs_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            mwrs_pkg::ST_IDLE: if (i_valid) r_job <= i_job;
            mwrs_pkg::ST_AB: begin
                r_a <= AW'(mwrs_pkg::ONE_Q16) + AW'(prod_a[35:16]);
                r_b <= AW'(prod_b[35:16]);
            end
            mwrs_pkg::ST_MUL: begin
                r_pa <= 35'(36'(r_job.c_spikes) * 36'(r_a));
                r_pb <= 55'(55'(r_job.s_sum) * 55'(r_b));
                r_qa <= 43'(44'(r_job.c_time) * 44'(r_a));
                r_qb <= 62'(63'(r_job.t_sum) * 63'(r_b));
            end
            mwrs_pkg::ST_SUM: begin
                r_rem <= NUMW'({r_pa, 16'd0} + 56'(r_pb)) << 8;
                r_div <= DW'(DENW'({r_qa, 16'd0}) + DENW'(r_qb)) << (QW - 1);
                r_q   <= '0;
                r_cnt <= 5'(QW - 1);
            end
            mwrs_pkg::ST_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_div[NUMW-1:0];
                end
                r_q   <= {r_q[QW-2:0], ge};
                r_div <= r_div >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            o_res.pixel_x <= r_job.pixel_x;
            o_res.pixel_y <= r_job.pixel_y;
            o_res.no_rate <= r_job.skip;
            o_res.rate    <= (r_job.skip || (sat < i_thresh)) ? 24'd0 : sat;
        end
    end

    assign o_res.valid = r_ovalid;

endmodule
`default_nettype wire

// ===== hdl/masked_weighted_rate_map_smoother.sv =====
// Top level of the masked weighted rate map smoother.
// Pixels of one map enter on i_pix in raster order (row 0 first, column 0 first);
// one result leaves on o_res for every interior pixel, with its position, the
// smoothed rate (Q16.8, saturated, zero below threshold) and a no-rate flag.
// Border pixels give no result. i_cfg writes map width (index 0), map height
// (1), smoothing factor (2, clamped to 1.0) and rate threshold (3); write only
// while the block is idle. The cfg channel is always ready.
// The front end takes one item per cycle into the window, border pixels included,
// unless an interior job waits for queue room, and hands the neighbor sums of its
// registered window to a four-entry job queue. For a result with a rate the back
// end steps through pop, coefficients, products, sum, a 25-step radix-2 divider
// and the output load; a no-rate result goes from pop straight to the output
// load. The back end pops no new job before the last one is loaded, so the
// divider sets the sustained rate of interior pixels.
// Reset clears counters, window, queue and output; registers return to 64x64,
// factor 0.5, threshold 0. The line store is not cleared and is valid once row
// data of the current map has been written.
// When o_res stalls, the held result stays; the back end then waits, the queue
// fills and i_pix.ready drops.
`default_nettype none
module masked_weighted_rate_map_smoother (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mwrs_pix_if.sink  i_pix,
    mwrs_cfg_if.sink  i_cfg,
    mwrs_res_if.source o_res
);
    logic [6:0]     r_width;
    logic [6:0]     r_height;
    logic [16:0]    r_smooth;
    logic [23:0]    r_thresh;
    logic [6:0]     width_c, height_c;
    logic           push, full, pop, q_valid;
    mwrs_pkg::t_job push_job, pop_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
            r_smooth <= 17'd32768;
            r_thresh <= 24'd0;
        end else if (i_cfg.valid) begin
            case (mwrs_pkg::t_reg_index'(i_cfg.index))
                mwrs_pkg::REG_MAP_WIDTH:  r_width  <= i_cfg.data[6:0];
                mwrs_pkg::REG_MAP_HEIGHT: r_height <= i_cfg.data[6:0];
                mwrs_pkg::REG_SMOOTHING:
                    r_smooth <= (i_cfg.data[16:0] > mwrs_pkg::ONE_Q16) ?
                                mwrs_pkg::ONE_Q16 : i_cfg.data[16:0];
                mwrs_pkg::REG_THRESHOLD:  r_thresh <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign width_c  = (r_width < 7'd3) ? 7'd3 :
                      (r_width > 7'(mwrs_pkg::MAX_WIDTH)) ? 7'(mwrs_pkg::MAX_WIDTH) : r_width;
    assign height_c = (r_height < 7'd3) ? 7'd3 :
                      (r_height > 7'(mwrs_pkg::MAX_HEIGHT)) ? 7'(mwrs_pkg::MAX_HEIGHT) : r_height;

    mwrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (width_c),
        .i_height (height_c),
        .i_pix    (i_pix),
        .i_full   (full),
        .o_push   (push),
        .o_job    (push_job)
    );

    mwrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    mwrs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smooth (r_smooth),
        .i_thresh (r_thresh),
        .i_valid  (q_valid),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire

// ===== sim/mwrs_check.sv =====
// Checker of the rate map smoother: watches the channels, predicts each result and compares.
`default_nettype none
module mwrs_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mwrs_pix_if       pix,
    mwrs_cfg_if       cfg,
    mwrs_res_if       res,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [23:0] rate;
        logic        no_rate;
    } t_smoothed;

    t_smoothed   smoothed_q[$];
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [16:0] factor_reg;
    logic [23:0] thresh_reg;
    logic [40:0] rows [2][64];
    logic [40:0] win [9];
    int unsigned col_pos;
    int unsigned row_pos;

    function automatic logic [63:0] tap_weight(input int i);
        if (i == 4) return 64'd0;
        if (i == 1 || i == 3 || i == 5 || i == 7) return 64'd65536;
        return 64'd46341;
    endfunction

    function automatic int unsigned clamp_dim(input logic [6:0] v);
        if (v < 3) return 3;
        if (v > 64) return 64;
        return v;
    endfunction

    // Blend the centre of the window with its occupied neighbors.
    function automatic t_smoothed smooth_window(input int unsigned x, input int unsigned y);
        t_smoothed   r;
        logic [63:0] n, s, t, a, b, num, den, q, w, sf;
        logic [40:0] c;
        r.pixel_x = 6'(x - 1);
        r.pixel_y = 6'(y - 1);
        r.rate = '0;
        r.no_rate = 1'b1;
        c = win[4];
        if (!c[40] || c[39:16] == 0) return r;
        n = 0;
        s = 0;
        t = 0;
        for (int i = 0; i < 9; i++) begin
            if (win[i][40]) begin
                w = tap_weight(i);
                n += w;
                s += 64'(win[i][15:0]) * w;
                t += 64'(win[i][39:16]) * w;
            end
        end
        sf = 64'(factor_reg);
        a = 64'd65536 + (((64'd65536 - sf) * n) >> 16);
        b = (sf * n) >> 16;
        num = 64'(c[15:0]) * a * 64'd65536 + s * b;
        den = 64'(c[39:16]) * a * 64'd65536 + t * b;
        if (den == 0) return r;
        q = (num << 8) / den;
        if (q > 64'hFFFFFF) q = 64'hFFFFFF;
        if (q < 64'(thresh_reg)) q = 0;
        r.rate = q[23:0];
        r.no_rate = 1'b0;
        return r;
    endfunction

    assign o_pending = smoothed_q.size();

    always @(posedge i_clk) begin
        int unsigned x;
        int unsigned w;
        int unsigned h;
        t_smoothed   got;
        t_smoothed   want;
        if (!i_rst_n) begin
            o_errors = 0;
            width_reg = 7'd64;
            height_reg = 7'd64;
            factor_reg = 17'd32768;
            thresh_reg = '0;
            foreach (rows[i, j]) rows[i][j] = '0;
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            smoothed_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (mwrs_pkg::t_reg_index'(cfg.index))
                    mwrs_pkg::REG_MAP_WIDTH:  width_reg = cfg.data[6:0];
                    mwrs_pkg::REG_MAP_HEIGHT: height_reg = cfg.data[6:0];
                    mwrs_pkg::REG_SMOOTHING:  factor_reg = (cfg.data[16:0] > 17'd65536) ?
                                                           17'd65536 : cfg.data[16:0];
                    mwrs_pkg::REG_THRESHOLD:  thresh_reg = cfg.data;
                    default: begin
                    end
                endcase
            end
            if (res.valid && res.ready) begin
                got = {res.pixel_x, res.pixel_y, res.rate, res.no_rate};
                if (smoothed_q.size() == 0) begin
                    $error("result with nothing expected: x=%0d y=%0d", got.pixel_x,
                           got.pixel_y);
                    o_errors++;
                end else begin
                    want = smoothed_q.pop_front();
                    if (got.pixel_x !== want.pixel_x) begin
                        $error("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x);
                        o_errors++;
                    end
                    if (got.pixel_y !== want.pixel_y) begin
                        $error("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y);
                        o_errors++;
                    end
                    if (got.rate !== want.rate) begin
                        $error("rate expected %0d got %0d", want.rate, got.rate);
                        o_errors++;
                    end
                    if (got.no_rate !== want.no_rate) begin
                        $error("no_rate expected %0d got %0d", want.no_rate, got.no_rate);
                        o_errors++;
                    end
                end
            end
            if (pix.valid && pix.ready) begin
                w = clamp_dim(width_reg);
                h = clamp_dim(height_reg);
                x = col_pos % 64;
                for (int r = 0; r < 3; r++) begin
                    win[r*3] = win[r*3+1];
                    win[r*3+1] = win[r*3+2];
                end
                win[2] = rows[0][x];
                win[5] = rows[1][x];
                win[8] = {pix.occupied, pix.dwell_time, pix.spike_count};
                rows[0][x] = win[5];
                rows[1][x] = win[8];
                if (x >= 2 && row_pos >= 2) smoothed_q.push_back(smooth_window(x, row_pos));
                if (x + 1 >= w) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
                end else begin
                    col_pos = x + 1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/masked_weighted_rate_map_smoother_test.sv =====
// Top of the rate map smoother testbench: clock, reset, stimulus and verdict.
`default_nettype none
module masked_weighted_rate_map_smoother_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   items_sent = 0;
    int   burst_left = 0;

    mwrs_pix_if pix ();
    mwrs_cfg_if cfg ();
    mwrs_res_if res ();

    masked_weighted_rate_map_smoother i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .i_cfg  (cfg),
        .o_res  (res)
    );

    mwrs_check i_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .pix      (pix),
        .cfg      (cfg),
        .res      (res),
        .o_errors (errors),
        .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("masked_weighted_rate_map_smoother verification failed");
            $finish;
        end
    end

    // Receiver: rotate through three stall patterns; hold off once for a long
    // stretch while the sender is offering items.
    initial begin
        int rcv_cycle;
        int hold_left;
        bit held;
        rcv_cycle = 0;
        hold_left = 0;
        held = 1'b0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rcv_cycle++;
            if (!held && items_sent >= 600 && pix.valid) begin
                held = 1'b1;
                hold_left = 2000;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready = 1'b0;
            end else begin
                case ((rcv_cycle / 256) % 3)
                    0:       res.ready = 1'b1;
                    1:       res.ready = 1'($urandom_range(0, 1));
                    default: res.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input mwrs_pkg::t_reg_index idx, input logic [23:0] value);
        @(negedge i_clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Offer one item; leave valid high so the next item can follow at once.
    task automatic send_pixel(input logic [15:0] spikes, input logic [23:0] dwell,
                              input logic occ, input bit gaps);
        if (gaps && burst_left == 0) begin
            pix.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        pix.valid = 1'b1;
        pix.spike_count = spikes;
        pix.dwell_time = dwell;
        pix.occupied = occ;
        do @(posedge i_clk); while (!pix.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic config_map(input logic [6:0] w, input logic [6:0] h,
                              input logic [16:0] sf, input logic [23:0] thr);
        write_reg(mwrs_pkg::REG_MAP_WIDTH, 24'(w));
        write_reg(mwrs_pkg::REG_MAP_HEIGHT, 24'(h));
        write_reg(mwrs_pkg::REG_SMOOTHING, 24'(sf));
        write_reg(mwrs_pkg::REG_THRESHOLD, thr);
    endtask

    task automatic send_random_map(input int unsigned w, input int unsigned h);
        logic [15:0] spikes;
        logic [23:0] dwell;
        bit          gaps;
        gaps = ($urandom_range(0, 3) != 0);
        for (int p = 0; p < w * h; p++) begin
            case ($urandom_range(0, 9))
                0:       spikes = 16'($urandom);
                1:       spikes = '0;
                default: spikes = 16'($urandom_range(0, 50));
            endcase
            case ($urandom_range(0, 9))
                0:       dwell = '0;
                1:       dwell = 24'($urandom);
                default: dwell = 24'($urandom_range(1, 4000));
            endcase
            send_pixel(spikes, dwell, $urandom_range(0, 9) != 0, gaps);
        end
        pix.valid = 1'b0;
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        logic [6:0]  w_reg;
        logic [6:0]  h_reg;
        logic [16:0] sf;
        logic [23:0] thr;
        pix.valid = 1'b0;
        pix.spike_count = '0;
        pix.dwell_time = '0;
        pix.occupied = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = mwrs_pkg::REG_MAP_WIDTH;
        cfg.data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed 5x5 map: zero centre time, unoccupied centre, saturation,
        // full-scale time and spike extremes.
        config_map(7'd5, 7'd5, 17'd32768, 24'd0);
        for (int p = 0; p < 25; p++) begin
            send_pixel((p % 3 == 0) ? 16'hFFFF : 16'(p),
                       (p == 6) ? 24'd0 : (p == 12) ? 24'd1 :
                       (p == 18) ? 24'hFFFFFF : 24'(p * 1000),
                       p != 7, 1'b0);
        end
        pix.valid = 1'b0;
        wait_idle();

        while (items_sent < 1800) begin
            case ($urandom_range(0, 19))
                0:       begin w_reg = 7'd64; h_reg = 7'd3; end
                1:       begin w_reg = 7'd3; h_reg = 7'd64; end
                2:       begin w_reg = 7'($urandom_range(0, 2));
                               h_reg = 7'($urandom_range(65, 127)); end
                3:       begin w_reg = 7'($urandom_range(65, 127));
                               h_reg = 7'($urandom_range(0, 2)); end
                default: begin w_reg = 7'($urandom_range(3, 8));
                               h_reg = 7'($urandom_range(3, 8)); end
            endcase
            // Keep the out-of-range heights small in cost: tall maps stay narrow.
            if (h_reg > 64) w_reg = 7'($urandom_range(0, 4));
            case ($urandom_range(0, 4))
                0:       sf = 17'd0;
                1:       sf = 17'd65536;
                2:       sf = 17'h1FFFF;
                default: sf = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 4))
                0:       thr = 24'd0;
                1:       thr = 24'hFFFFFF;
                2:       thr = 24'($urandom);
                default: thr = 24'($urandom_range(0, 3000));
            endcase
            config_map(w_reg, h_reg, sf, thr);
            w = (w_reg < 3) ? 3 : (w_reg > 64) ? 64 : w_reg;
            h = (h_reg < 3) ? 3 : (h_reg > 64) ? 64 : h_reg;
            send_random_map(w, h);
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("masked_weighted_rate_map_smoother verification clean");
        else
            $display("masked_weighted_rate_map_smoother verification failed");
        $finish;
    end
endmodule
`default_nettype wire
